[src/slg_pkg.sv]
// slg_pkg: shared constants for the selectable congruential / shift register generator.
// Holds register indexes, mode codes, port widths and reset values.
// No dependencies.
`timescale 1ns / 1ps

package slg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LCG_SEED   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_LEN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MASK   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_SEED = 3'd7;

  localparam logic MODE_LCG  = 1'b0;
  localparam logic MODE_LFSR = 1'b1;

  localparam logic [LEN_W-1:0]      LEN_RST = 7'd16;
  localparam logic [CFG_DATA_W-1:0] TAP_RST = 64'h0000_0000_0000_B400;

endpackage

[src/slg_rem_unit.sv]
// slg_rem_unit: restoring remainder unit, one dividend bit per cycle.
// Takes a 2*LCG_BITS dividend and an LCG_BITS divisor, returns the remainder.
// Standalone; used by selectable_lcg_lfsr_generator_unit.
`timescale 1ns / 1ps

module slg_rem_unit #(
  parameter int LCG_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*LCG_BITS-1:0] dividend,
  input  logic [LCG_BITS-1:0]   divisor,
  output logic                  done,
  output logic [LCG_BITS-1:0]   rem
);

  localparam int DVD_W = 2 * LCG_BITS;
  localparam int CNT_W = $clog2(DVD_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [LCG_BITS-1:0] rem_r, rem_nxt;
  logic [LCG_BITS:0]   rem_sh;
  logic [LCG_BITS:0]   rem_diff;

  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      if (rem_sh >= {1'b0, divisor}) begin
        rem_nxt = rem_diff[LCG_BITS-1:0];
      end else begin
        rem_nxt = rem_sh[LCG_BITS-1:0];
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("remainder unit not busy after start");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == '0) |=> (done_r && !busy_r))
    else $error("remainder unit missed its last step");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && divisor != '0) |-> (rem_r < divisor))
    else $error("remainder not below divisor");

endmodule

[src/selectable_lcg_lfsr_generator_unit.sv]
// selectable_lcg_lfsr_generator_unit: pseudo-random number source, congruential or LFSR.
// Top level; depends on slg_pkg and slg_rem_unit.
//
// Usage:
//   in_valid/in_ready/in_draw: one item per request. An item with in_draw low is
//   taken and dropped, no result. in_ready is high only while the sequencer idles.
//   out_valid/out_ready/out_value: one result item per draw. Held in an output
//   register; a new draw is taken while it still waits, but the next result is
//   only loaded once the previous one has gone.
//   cfg_valid/cfg_ready/cfg_index/cfg_data: register writes, taken while idle.
//   A write of lcg_seed or shift_seed also loads the matching generator state.
// Steps, accept to out_valid:
//   mode 0: a multiply-add step, then the remainder unit retires one dividend bit
//   per cycle; the remainder step is skipped when the modulus is zero.
//   mode 1: one register step per cycle, one step per output bit.
//   A new draw is taken only once the previous result is in the output register.
// Reset (rst_n low, synchronous): registers take their reset values, the states
// take the seed resets, no result pending.
// A stalled receiver holds the finished item in the output register; the
// sequencer then waits at its final step.
`timescale 1ns / 1ps

module selectable_lcg_lfsr_generator_unit #(
  parameter int SHIFT_MAX = 64,
  parameter int OUT_BITS  = 63,
  parameter int LCG_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_draw,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [OUT_BITS-1:0]            out_value,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [slg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slg_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int PROD_W = 2 * LCG_BITS;
  localparam int IDX_W  = $clog2(SHIFT_MAX);
  localparam int CNT_W  = $clog2(OUT_BITS + 1);
  localparam int ST_W   = 3;

  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_MUL  = 3'd1;
  localparam logic [ST_W-1:0] ST_MODQ = 3'd2;
  localparam logic [ST_W-1:0] ST_DIV  = 3'd3;
  localparam logic [ST_W-1:0] ST_LFSR = 3'd4;
  localparam logic [ST_W-1:0] ST_FIN  = 3'd5;

  // configuration
  logic                          mode_r;
  logic [LCG_BITS-1:0]           mult_r;
  logic [LCG_BITS-1:0]           incr_r;
  logic [LCG_BITS-1:0]           mod_r;
  logic [slg_pkg::LEN_W-1:0]     len_r;
  logic [SHIFT_MAX-1:0]          tap_r;

  // sequencer and datapath
  logic [ST_W-1:0]               state_r, state_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [LCG_BITS-1:0]           x_r, x_nxt;
  logic [SHIFT_MAX-1:0]          sh_r, sh_nxt;
  logic [OUT_BITS-1:0]           res_r, res_nxt;
  logic [PROD_W-1:0]             prod_r, prod_nxt;
  logic [OUT_BITS-1:0]           out_value_r, out_value_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic                          in_acc;
  logic                          cfg_acc;
  logic [PROD_W-1:0]             prod_mul;
  logic [slg_pkg::LEN_W-1:0]     len_eff;
  logic [IDX_W-1:0]              len_m1;
  logic [SHIFT_MAX-1:0]          keep;
  logic                          fb;
  logic                          oldest;
  logic                          rem_start;
  logic                          rem_done;
  logic [LCG_BITS-1:0]           rem_val;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // effective register length, clamped to 2..SHIFT_MAX
  always_comb begin
    if (len_r < slg_pkg::LEN_W'(2)) begin
      len_eff = slg_pkg::LEN_W'(2);
    end else if (len_r > slg_pkg::LEN_W'(SHIFT_MAX)) begin
      len_eff = slg_pkg::LEN_W'(SHIFT_MAX);
    end else begin
      len_eff = len_r;
    end
  end

  assign len_m1 = IDX_W'(len_eff - 1'b1);

  always_comb begin
    for (int i = 0; i < SHIFT_MAX; i++) begin
      keep[i] = (slg_pkg::LEN_W'(i) < len_eff);
    end
  end

  assign fb       = ^(sh_r & tap_r);
  assign oldest   = sh_r[len_m1];
  assign prod_mul = mult_r * x_r;

  assign rem_start = (state_r == ST_MODQ) && (mod_r != '0);

  slg_rem_unit #(
    .LCG_BITS (LCG_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (prod_r),
    .divisor  (mod_r),
    .done     (rem_done),
    .rem      (rem_val)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    sh_nxt        = sh_r;
    res_nxt       = res_r;
    prod_nxt      = prod_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (cfg_acc && cfg_index == slg_pkg::CFG_LCG_SEED) begin
          x_nxt = cfg_data[LCG_BITS-1:0];
        end
        if (cfg_acc && cfg_index == slg_pkg::CFG_SHIFT_SEED) begin
          sh_nxt = cfg_data[SHIFT_MAX-1:0];
        end
        if (in_acc && in_draw) begin
          if (mode_r == slg_pkg::MODE_LFSR) begin
            sh_nxt    = sh_r & keep;
            cnt_nxt   = CNT_W'(OUT_BITS - 1);
            state_nxt = ST_LFSR;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = prod_mul + PROD_W'(incr_r);
        state_nxt = ST_MODQ;
      end
      ST_MODQ: begin
        if (mod_r == '0) begin
          x_nxt     = prod_r[LCG_BITS-1:0];
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_done) begin
          x_nxt     = rem_val;
          state_nxt = ST_FIN;
        end
      end
      ST_LFSR: begin
        res_nxt = OUT_BITS'({res_r, oldest});
        sh_nxt  = ((sh_r << 1) | SHIFT_MAX'(fb)) & keep;
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (mode_r == slg_pkg::MODE_LFSR) begin
            out_value_nxt = res_r;
          end else begin
            out_value_nxt = OUT_BITS'(x_r);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      x_r         <= '0;
      sh_r        <= SHIFT_MAX'(1);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      x_r         <= x_nxt;
      sh_r        <= sh_nxt;
    end
    res_r       <= res_nxt;
    prod_r      <= prod_nxt;
    out_value_r <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= slg_pkg::MODE_LCG;
      mult_r <= LCG_BITS'(1);
      incr_r <= LCG_BITS'(1);
      mod_r  <= '1;
      len_r  <= slg_pkg::LEN_RST;
      tap_r  <= slg_pkg::TAP_RST[SHIFT_MAX-1:0];
    end else if (cfg_acc) begin
      case (cfg_index)
        slg_pkg::CFG_MODE:       mode_r <= cfg_data[0];
        slg_pkg::CFG_MULTIPLIER: mult_r <= cfg_data[LCG_BITS-1:0];
        slg_pkg::CFG_INCREMENT:  incr_r <= cfg_data[LCG_BITS-1:0];
        slg_pkg::CFG_MODULUS:    mod_r  <= cfg_data[LCG_BITS-1:0];
        slg_pkg::CFG_SHIFT_LEN:  len_r  <= cfg_data[slg_pkg::LEN_W-1:0];
        slg_pkg::CFG_TAP_MASK:   tap_r  <= cfg_data[SHIFT_MAX-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  a_busy_after_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_draw) |=> !in_ready)
    else $error("draw item accepted but sequencer still idle");

  a_rem_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == ST_DIV))
    else $error("remainder finished outside the divide step");

  a_lcg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && mode_r == slg_pkg::MODE_LCG && mod_r != '0) |-> (x_r < mod_r))
    else $error("congruential state not below modulus");

  a_lfsr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && mode_r == slg_pkg::MODE_LFSR) |-> ((sh_r & ~keep) == '0))
    else $error("shift register bits set above the length");

endmodule

[sim/tb_selectable_lcg_lfsr_generator_unit.sv]
// Testbench for selectable_lcg_lfsr_generator_unit: directed and random draws in both modes,
// checked item by item against a behavioural predictor of the congruential and LFSR paths.
// Depends on slg_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_selectable_lcg_lfsr_generator_unit;

  localparam int OUT_W       = 63;
  localparam int LCG_W       = 32;
  localparam int SHIFT_W     = 64;
  localparam int SETTLE      = 2 * LCG_W + 16;
  localparam int CYCLE_LIMIT = 800000;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_draw   = 1'b0;
  logic                           out_ready = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [slg_pkg::CFG_IDX_W-1:0]  cfg_index = slg_pkg::CFG_MODE;
  logic [slg_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                           in_ready;
  logic                           out_valid;
  logic [OUT_W-1:0]               out_value;
  logic                           cfg_ready;

  // predictor state, reset values
  logic                        gen_mode    = slg_pkg::MODE_LCG;
  logic [LCG_W-1:0]            gen_mult    = 32'd1;
  logic [LCG_W-1:0]            gen_incr    = 32'd1;
  logic [LCG_W-1:0]            gen_mod     = 32'hFFFF_FFFF;
  logic [slg_pkg::LEN_W-1:0]   gen_len     = slg_pkg::LEN_RST;
  logic [SHIFT_W-1:0]          gen_taps    = slg_pkg::TAP_RST;
  logic [LCG_W-1:0]            lcg_state   = '0;
  logic [SHIFT_W-1:0]          shift_state = 64'd1;

  logic             draw_queue[$];
  logic [OUT_W-1:0] expected_values[$];
  int               queued_count   = 0;
  int               accepted_count = 0;
  int               draws_taken    = 0;
  int               results_seen   = 0;
  int               writes_done    = 0;
  int               error_count    = 0;
  int               cycle_count    = 0;
  logic             steady         = 1'b0;

  selectable_lcg_lfsr_generator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_draw   (in_draw),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [OUT_W-1:0] next_congruential();
    logic [63:0] t;
    t = {32'd0, gen_mult} * {32'd0, lcg_state} + {32'd0, gen_incr};
    if (gen_mod == '0) begin
      t = t & 64'h0000_0000_FFFF_FFFF;
    end else begin
      t = t % {32'd0, gen_mod};
    end
    lcg_state = t[LCG_W-1:0];
    return {{(OUT_W-LCG_W){1'b0}}, lcg_state};
  endfunction

  function automatic logic [OUT_W-1:0] next_shift_run();
    int               len;
    logic [63:0]      keep;
    logic [63:0]      r;
    logic [OUT_W-1:0] bits;
    logic             fb;
    len = int'(gen_len);
    if (len < 2) len = 2;
    if (len > SHIFT_W) len = SHIFT_W;
    keep = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
    r = shift_state & keep;
    bits = '0;
    for (int i = 0; i < OUT_W; i++) begin
      fb = ^(r & gen_taps);
      bits = {bits[OUT_W-2:0], r[len-1]};
      r = ((r << 1) | {63'd0, fb}) & keep;
    end
    shift_state = r;
    return bits;
  endfunction

  function automatic void apply_draw(logic draw);
    if (draw) begin
      if (gen_mode == slg_pkg::MODE_LCG) expected_values.push_back(next_congruential());
      else expected_values.push_back(next_shift_run());
    end
  endfunction

  function automatic void apply_write(logic [slg_pkg::CFG_IDX_W-1:0] idx,
                                      logic [slg_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      slg_pkg::CFG_MODE:       gen_mode = data[0];
      slg_pkg::CFG_MULTIPLIER: gen_mult = data[LCG_W-1:0];
      slg_pkg::CFG_INCREMENT:  gen_incr = data[LCG_W-1:0];
      slg_pkg::CFG_MODULUS:    gen_mod  = data[LCG_W-1:0];
      slg_pkg::CFG_LCG_SEED:   lcg_state = data[LCG_W-1:0];
      slg_pkg::CFG_SHIFT_LEN:  gen_len = data[slg_pkg::LEN_W-1:0];
      slg_pkg::CFG_TAP_MASK:   gen_taps = data;
      slg_pkg::CFG_SHIFT_SEED: shift_state = data;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    $display("[%0t] mismatch: %s got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  // driver: one item in flight, idles at random unless steady
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_draw(in_draw);
        accepted_count++;
        if (in_draw) draws_taken++;
      end
      if (!in_valid || in_ready) begin
        if (draw_queue.size() > 0 && (steady || $urandom_range(99) >= 17)) begin
          in_valid <= 1'b1;
          in_draw  <= draw_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_values.size() == 0) begin
          report_mismatch("unexpected item, value", out_value, '0);
        end else if (out_value !== expected_values[0]) begin
          report_mismatch("value", out_value, expected_values.pop_front());
        end else begin
          void'(expected_values.pop_front());
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
               expected_values.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void add_draw(logic d);
    draw_queue.push_back(d);
    queued_count++;
  endfunction

  function automatic void add_draws(int n);
    for (int i = 0; i < n; i++) add_draw($urandom_range(99) >= 8);
  endfunction

  task automatic write_reg(logic [slg_pkg::CFG_IDX_W-1:0] idx,
                           logic [slg_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_write(idx, data);
    writes_done++;
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (accepted_count != queued_count || expected_values.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic shuffle_config();
    logic [63:0] r;
    r = {$urandom, $urandom};
    write_reg(slg_pkg::CFG_MODE, {r[63:1], 1'($urandom_range(1))});
    if ($urandom_range(9) < 6) begin
      case ($urandom_range(3))
        0: write_reg(slg_pkg::CFG_MULTIPLIER, '1);
        1: write_reg(slg_pkg::CFG_MULTIPLIER, 64'($urandom_range(0, 255)));
        default: write_reg(slg_pkg::CFG_MULTIPLIER, {$urandom, $urandom});
      endcase
    end
    if ($urandom_range(9) < 6) write_reg(slg_pkg::CFG_INCREMENT, {$urandom, $urandom});
    if ($urandom_range(9) < 6) begin
      case ($urandom_range(5))
        0: write_reg(slg_pkg::CFG_MODULUS, '0);
        1: write_reg(slg_pkg::CFG_MODULUS, 64'hFFFF_FFFF);
        2: write_reg(slg_pkg::CFG_MODULUS, 64'($urandom_range(1, 16)));
        3: write_reg(slg_pkg::CFG_MODULUS, 64'($urandom_range(1, 65535)));
        default: write_reg(slg_pkg::CFG_MODULUS, {$urandom, $urandom});
      endcase
    end
    if ($urandom_range(9) < 6) write_reg(slg_pkg::CFG_LCG_SEED, {$urandom, $urandom});
    if ($urandom_range(9) < 6) begin
      case ($urandom_range(3))
        0: write_reg(slg_pkg::CFG_SHIFT_LEN, {$urandom, 25'd0, 7'($urandom_range(0, 127))});
        1: write_reg(slg_pkg::CFG_SHIFT_LEN, 64'($urandom_range(2, 8)));
        default: write_reg(slg_pkg::CFG_SHIFT_LEN, 64'($urandom_range(2, 64)));
      endcase
    end
    if ($urandom_range(9) < 6) begin
      r = {$urandom, $urandom};
      if ($urandom_range(1)) r = r & {$urandom, $urandom};
      write_reg(slg_pkg::CFG_TAP_MASK, r);
    end
    if ($urandom_range(9) < 6) write_reg(slg_pkg::CFG_SHIFT_SEED, {$urandom, $urandom});
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, idle item in the middle
    add_draw(1'b1); add_draw(1'b0); add_draw(1'b1); add_draw(1'b1);
    settle();
    write_reg(slg_pkg::CFG_MODE, {63'd0, slg_pkg::MODE_LFSR});
    add_draw(1'b1); add_draw(1'b1);
    settle();

    // congruential extremes; upper data bits must be ignored
    write_reg(slg_pkg::CFG_MODE, {63'h7FFF_FFFF_FFFF_FFFF, slg_pkg::MODE_LCG});
    write_reg(slg_pkg::CFG_MULTIPLIER, '1);
    write_reg(slg_pkg::CFG_INCREMENT, '1);
    write_reg(slg_pkg::CFG_MODULUS, 64'hFFFF_FFFF);
    write_reg(slg_pkg::CFG_LCG_SEED, '1);
    add_draw(1'b1); add_draw(1'b1);
    settle();
    write_reg(slg_pkg::CFG_MODULUS, '0);
    add_draw(1'b1); add_draw(1'b1);
    settle();
    write_reg(slg_pkg::CFG_MODULUS, 64'd1);
    add_draw(1'b1);
    settle();
    write_reg(slg_pkg::CFG_MODULUS, 64'd7);
    write_reg(slg_pkg::CFG_LCG_SEED, 64'd1000);
    add_draw(1'b1);
    settle();

    // shift register lengths out of range, full taps, no taps
    write_reg(slg_pkg::CFG_MODE, {63'd0, slg_pkg::MODE_LFSR});
    write_reg(slg_pkg::CFG_SHIFT_LEN, 64'hFFFF_FFFF_FFFF_FF80);
    add_draw(1'b1);
    settle();
    write_reg(slg_pkg::CFG_SHIFT_LEN, 64'd1);
    add_draw(1'b1);
    settle();
    write_reg(slg_pkg::CFG_SHIFT_LEN, 64'd127);
    write_reg(slg_pkg::CFG_TAP_MASK, '1);
    write_reg(slg_pkg::CFG_SHIFT_SEED, '1);
    add_draw(1'b1);
    settle();
    write_reg(slg_pkg::CFG_SHIFT_LEN, 64'd65);
    write_reg(slg_pkg::CFG_SHIFT_SEED, 64'hDEAD_BEEF_0123_4567);
    add_draw(1'b1);
    settle();
    write_reg(slg_pkg::CFG_SHIFT_LEN, 64'd2);
    write_reg(slg_pkg::CFG_SHIFT_SEED, '1);
    add_draw(1'b1);
    settle();
    write_reg(slg_pkg::CFG_SHIFT_LEN, 64'd64);
    write_reg(slg_pkg::CFG_TAP_MASK, '0);
    add_draw(1'b1);
    settle();

    for (int phase = 0; phase < 22; phase++) begin
      shuffle_config();
      steady = (phase == 11);
      add_draws(steady ? 150 : 45);
      settle();
      steady = 1'b0;
    end

    $display("%0d draws in both modes, %0d results checked, %0d register writes",
             draws_taken, results_seen, writes_done);
    $display("covered zero and unit modulus, clamped lengths, empty and full tap masks");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/slg_pkg.sv
src/slg_rem_unit.sv
src/selectable_lcg_lfsr_generator_unit.sv
sim/tb_selectable_lcg_lfsr_generator_unit.sv
